/* sv/kst_pkg.sv */
// Shared types and codes for the keyed slot table.
package kst_pkg;

	// Request kinds
	typedef enum logic {
		ACT_INSTALL = 1'b0,
		ACT_LOOKUP  = 1'b1
	} kst_action_e;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_SLOT   = 2'd1,
		ST_NOT_FOUND = 2'd2
	} kst_status_e;

	// Control states, one-hot
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_RESP = 3'b100
	} kst_state_t;

	localparam int unsigned KEY_W = 32;
	localparam int unsigned VAL_W = 32;

	// One stored slot
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] handle;
		logic [VAL_W-1:0] length;
	} slot_entry_t;

	// One result before it reaches the output register
	typedef struct packed {
		kst_status_e      status;
		logic [VAL_W-1:0] found_handle;
		logic [VAL_W-1:0] found_length;
		logic             replaced;
		logic [VAL_W-1:0] old_handle;
	} kst_result_t;

endpackage

/* sv/kst_slot_ram.sv */
// Simple dual-port slot memory with a registered read port.
module kst_slot_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6,
	parameter int unsigned DW    = 96
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* sv/keyed_slot_table.sv */
// Keyed slot table top level: install/replace and lookup by a 32-bit key.
//
// Channel  Dir  Handshake              Payload
// s_axis   in   s_axis_tvalid/tready   tuser: action; tdata: port_name, blob_handle, blob_length
// m_axis   out  m_axis_tvalid/tready   tuser: status, replaced; tdata: found_handle,
//                                      found_length, old_handle
//
// Each request scans the filled slots one per cycle through the single memory read port.
// A hit ends the scan at the first matching slot; a miss ends it once every filled slot
// has been read, or at once on an empty table.
// Slots are never freed, so the filled slots are always 0 .. count-1 and a fill count
// stands in for valid marks: reset clears the count but not the slot memory, and needs no clearing pass.
// A finished result waits in the output register; a new request is taken meanwhile, and
// its own result waits in the response state until the output register frees up.
module keyed_slot_table
	import kst_pkg::*;
#(
	parameter int unsigned SLOTS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,  // port_name[31:0], blob_handle[63:32], blob_length[95:64]
	input  logic [0:0]   s_axis_tuser,  // action[0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [95:0]  m_axis_tdata,  // found_handle[31:0], found_length[63:32], old_handle[95:64]
	output logic [2:0]   m_axis_tuser   // status[1:0], replaced[2]
);

	localparam int unsigned CW = $clog2(SLOTS + 1);
	localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned DW = $bits(slot_entry_t);

	kst_state_t        state_q;
	kst_action_e       act_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  hnd_q;
	logic [VAL_W-1:0]  len_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     rd_idx_q;
	logic              cmp_valid_s1;
	logic [AW-1:0]     cmp_idx_s1;
	kst_result_t       res_q;
	logic              m_valid_q;
	kst_result_t       out_q;

	logic              in_fire;
	logic              rd_en;
	logic              hit;
	logic              miss;
	logic              finish;
	logic              full;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	slot_entry_t       wr_data;
	slot_entry_t       rd_data;
	logic [DW-1:0]     rd_raw;
	kst_result_t       res_d;
	logic              out_load;
	logic              count_inc;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// Scan control: read filled slots in order, compare in the next cycle
	assign rd_en   = (state_q == S_SCAN) && (rd_idx_q < count_q);
	assign rd_data = slot_entry_t'(rd_raw);
	assign hit     = (state_q == S_SCAN) && cmp_valid_s1 && (rd_data.key == key_q);
	assign miss    = (state_q == S_SCAN) && !cmp_valid_s1 && (rd_idx_q == count_q);
	assign finish  = hit || miss;
	assign full    = (count_q == CW'(SLOTS));

	// Write back: replace in place on a hit, append at the fill count otherwise unless the table is full
	assign wr_en     = finish && (act_q == ACT_INSTALL) && (hit || !full);
	assign wr_addr   = hit ? cmp_idx_s1 : count_q[AW-1:0];
	assign count_inc = wr_en && !hit;
	always_comb begin
		wr_data.key    = key_q;
		wr_data.handle = hnd_q;
		wr_data.length = len_q;
	end

	// Result of the request being finished
	always_comb begin
		res_d.status       = ST_OK;
		res_d.found_handle = '0;
		res_d.found_length = '0;
		res_d.replaced     = 1'b0;
		res_d.old_handle   = '0;
		case (act_q)
			ACT_INSTALL: begin
				if (hit) begin
					res_d.replaced   = 1'b1;
					res_d.old_handle = rd_data.handle;
				end else if (full) begin
					res_d.status = ST_NO_SLOT;
				end
			end
			ACT_LOOKUP: begin
				if (hit) begin
					res_d.found_handle = rd_data.handle;
					res_d.found_length = rd_data.length;
				end else begin
					res_d.status = ST_NOT_FOUND;
				end
			end
			default: begin
				res_d.status = ST_OK;
			end
		endcase
	end

	assign out_load = (state_q == S_RESP) && (!m_valid_q || m_axis_tready);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			rd_idx_q     <= '0;
			cmp_valid_s1 <= 1'b0;
		end else begin
			cmp_valid_s1 <= rd_en;
			if (count_inc) begin
				count_q <= count_q + CW'(1);
			end
			case (state_q)
				S_IDLE: begin
					rd_idx_q <= '0;
					if (in_fire) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (finish) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request capture and scan payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_q <= kst_action_e'(s_axis_tuser[0]);
			key_q <= s_axis_tdata[31:0];
			hnd_q <= s_axis_tdata[63:32];
			len_q <= s_axis_tdata[95:64];
		end
		cmp_idx_s1 <= rd_idx_q[AW-1:0];
		if (finish) begin
			res_q <= res_d;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {out_q.old_handle, out_q.found_length, out_q.found_handle};
	assign m_axis_tuser  = {out_q.replaced, out_q.status};

	kst_slot_ram #(
		.DEPTH (SLOTS),
		.AW    (AW),
		.DW    (DW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (rd_raw)
	);

`ifndef SYNTHESIS
	// Fill count never passes the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SLOTS))
		else $error("fill count beyond table size");

	// Fill count grows by one at most
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + CW'(1)))
		else $error("fill count jumped");

	// Memory is written only when a scan ends
	a_write_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_SCAN) && finish)
		else $error("slot write outside scan end");

	// A new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_axis_tready) |=> $stable(out_q))
		else $error("pending result overwritten");

	// Scan never reads past the filled slots
	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (rd_idx_q < count_q))
		else $error("read beyond filled slots");
`endif

endmodule
